### sv/ufr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants of the union-find engine: the item and result
// payloads and the fixed field widths.
// ----------------------------------------------------------------------------
package ufr_pkg;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int RANK_W = 4;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;

  // Item kinds.
  localparam logic KIND_MERGE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] first_index;
    logic [IDX_W-1:0] second_index;
  } in_item_t;

  typedef struct packed {
    logic             already_same;
    logic [IDX_W-1:0] root_index;
    logic [CNT_W-1:0] set_size;
    logic [CNT_W-1:0] component_count;
    logic             index_error;
  } out_item_t;

endpackage
`default_nettype wire

### sv/ufr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ufr_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered (old data on a same-address collision).
// ----------------------------------------------------------------------------
module ufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/union_find_by_rank_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_by_rank_top
// Disjoint-set engine with union by rank and full path compression.
// ----------------------------------------------------------------------------
// Usage:
//   One item is taken on the in_ channel (valid/ready); it yields exactly one
//   result transfer on the out_ channel. A merge walks from first_index to its
//   root, rewrites that path, does the same for second_index and then, if the
//   two roots differ, links them with two writes. A query only walks both paths.
//   Each hop of a walk and each path rewrite is one access to the single
//   node-table RAM; with balanced ranks a hop count stays near log2(ELEMENTS).
//   An index error skips the walks and goes straight to loading the output
//   register. Items are handled one at a time.
//   The result waits in an output register; the next item can be accepted
//   while it waits, but finishing that item stalls until the result is taken.
//   After reset and after every cfg_ write the RAM is reinitialized by a
//   clearing pass over all ELEMENTS entries, during which in_ready is low.
// ----------------------------------------------------------------------------
module union_find_by_rank_top #(
  parameter int ELEMENTS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire ufr_pkg::in_item_t      in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output ufr_pkg::out_item_t          out_data,
  input  wire logic                   cfg_we,
  input  wire logic [ufr_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(ELEMENTS);
  localparam int RW = ufr_pkg::RANK_W;
  localparam int CW = ufr_pkg::CNT_W;
  localparam int IW = ufr_pkg::IDX_W;
  localparam int WW = AW + RW + CW;
  localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENTS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FA   = 4'd2;
  localparam logic [3:0] S_CA   = 4'd3;
  localparam logic [3:0] S_FB   = 4'd4;
  localparam logic [3:0] S_CB   = 4'd5;
  localparam logic [3:0] S_LNK1 = 4'd6;
  localparam logic [3:0] S_LNK2 = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // Clamp the configured count to 1..ELEMENTS.
  function automatic logic [CW-1:0] clamp_count(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CW'(1);
    end else if (32'(v) > ELEMENTS) begin
      r = CW'(ELEMENTS);
    end
    return r;
  endfunction

  logic [3:0]      state_r, state_nxt;
  logic [CW-1:0]   cfg_r, cfg_nxt;
  logic [CW-1:0]   set_count_r, set_count_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic            kind_r, kind_nxt;
  logic            err_r, err_nxt;
  logic [AW-1:0]   b_r, b_nxt;
  logic [AW-1:0]   a_r, a_nxt;
  logic [AW-1:0]   cur_r, cur_nxt;
  logic [AW-1:0]   ra_r, ra_nxt;
  logic [AW-1:0]   rb_r, rb_nxt;
  logic [RW-1:0]   rank_a_r, rank_a_nxt;
  logic [RW-1:0]   rank_b_r, rank_b_nxt;
  logic [CW-1:0]   size_a_r, size_a_nxt;
  logic [CW-1:0]   size_b_r, size_b_nxt;
  ufr_pkg::out_item_t out_r, out_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [WW-1:0]   ram_wdata, ram_rdata;
  logic [AW-1:0]   rd_parent;
  logic [RW-1:0]   rd_rank;
  logic [CW-1:0]   rd_size;
  logic [CW-1:0]   n_eff;
  logic            a_bad, b_bad;
  logic            swap;
  logic [RW-1:0]   lo_rank, hi_rank;

  ufr_ram #(.WIDTH(WW), .DEPTH(ELEMENTS)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Node word: parent, rank, size.
  assign rd_parent = ram_rdata[WW-1 -: AW];
  assign rd_rank   = ram_rdata[CW +: RW];
  assign rd_size   = ram_rdata[CW-1:0];

  assign n_eff = clamp_count(cfg_r);
  assign a_bad = {1'b0, in_data.first_index} >= n_eff;
  assign b_bad = {1'b0, in_data.second_index} >= n_eff;

  // Linking order: the lower-rank root goes under the other one.
  assign swap    = rank_a_r > rank_b_r;
  assign lo_rank = swap ? rank_b_r : rank_a_r;
  assign hi_rank = swap ? rank_a_r : rank_b_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    cfg_nxt       = cfg_r;
    set_count_nxt = set_count_r;
    clr_cnt_nxt   = clr_cnt_r;
    kind_nxt      = kind_r;
    err_nxt       = err_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rank_a_nxt    = rank_a_r;
    rank_b_nxt    = rank_b_r;
    size_a_nxt    = size_a_r;
    size_b_nxt    = size_b_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ram_we        = 1'b0;
    ram_waddr     = cur_r;
    ram_wdata     = {ra_r, rd_rank, rd_size};
    ram_raddr     = cur_r;

    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = {clr_cnt_r, RW'(0), CW'(1)};
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          err_nxt   = a_bad || b_bad;
          a_nxt     = AW'(in_data.first_index);
          b_nxt     = AW'(in_data.second_index);
          cur_nxt   = AW'(in_data.first_index);
          ram_raddr = AW'(in_data.first_index);
          state_nxt = (a_bad || b_bad) ? S_DONE : S_FA;
        end
      end
      S_FA: begin
        if (rd_parent == cur_r) begin
          ra_nxt     = cur_r;
          rank_a_nxt = rd_rank;
          size_a_nxt = rd_size;
          if (kind_r == ufr_pkg::KIND_MERGE) begin
            cur_nxt   = a_r;
            ram_raddr = a_r;
            state_nxt = S_CA;
          end else begin
            cur_nxt   = b_r;
            ram_raddr = b_r;
            state_nxt = S_FB;
          end
        end else begin
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      S_CA: begin
        if (cur_r == ra_r) begin
          cur_nxt   = b_r;
          ram_raddr = b_r;
          state_nxt = S_FB;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {ra_r, rd_rank, rd_size};
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      S_FB: begin
        if (rd_parent == cur_r) begin
          rb_nxt     = cur_r;
          rank_b_nxt = rd_rank;
          size_b_nxt = rd_size;
          if (kind_r == ufr_pkg::KIND_MERGE) begin
            cur_nxt   = b_r;
            ram_raddr = b_r;
            state_nxt = S_CB;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      S_CB: begin
        if (cur_r == rb_r) begin
          state_nxt = (ra_r == rb_r) ? S_DONE : S_LNK1;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = {rb_r, rd_rank, rd_size};
          cur_nxt   = rd_parent;
          ram_raddr = rd_parent;
        end
      end
      S_LNK1: begin
        // Hang the lower root under the higher one and fold in its size.
        // When swapped the two roots trade places, so rb_r holds the surviving root.
        ram_we     = 1'b1;
        ram_waddr  = swap ? rb_r : ra_r;
        ram_wdata  = swap ? {ra_r, rank_b_r, size_b_r} : {rb_r, rank_a_r, size_a_r};
        ra_nxt     = swap ? rb_r : ra_r;
        rb_nxt     = swap ? ra_r : rb_r;
        size_b_nxt = size_a_r + size_b_r;
        rank_b_nxt = (lo_rank == hi_rank && hi_rank != ufr_pkg::RANK_MAX) ?
                     hi_rank + RW'(1) : hi_rank;
        if (set_count_r > CW'(1)) begin
          set_count_nxt = set_count_r - CW'(1);
        end
        state_nxt  = S_LNK2;
      end
      S_LNK2: begin
        ram_we    = 1'b1;
        ram_waddr = rb_r;
        ram_wdata = {rb_r, rank_b_r, size_b_r};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_nxt.component_count = set_count_r;
          out_nxt.index_error     = err_r;
          if (err_r) begin
            out_nxt.already_same = 1'b0;
            out_nxt.root_index   = '0;
            out_nxt.set_size     = '0;
          end else begin
            out_nxt.already_same = (ra_r == rb_r);
            out_nxt.root_index   = IW'(rb_r);
            out_nxt.set_size     = size_b_r;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase

    // A count write restarts the engine from scratch.
    if (cfg_we) begin
      cfg_nxt       = cfg_wdata;
      set_count_nxt = clamp_count(cfg_wdata);
      clr_cnt_nxt   = '0;
      state_nxt     = S_CLR;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cfg_r       <= CW'(1024);
      set_count_r <= clamp_count(CW'(1024));
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_r       <= cfg_nxt;
      set_count_r <= set_count_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    err_r    <= err_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    rank_a_r <= rank_a_nxt;
    rank_b_r <= rank_b_nxt;
    size_a_r <= size_a_nxt;
    size_b_r <= size_b_nxt;
    out_r    <= out_nxt;
  end

  // One item at a time: no second transfer right after an accepted one.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // The component count only falls, except on a count write.
  a_count_falls: assert property (@(posedge clk) disable iff (!rst_n)
    (!cfg_we && rst_n) |=> (set_count_r <= $past(set_count_r)))
    else $error("component count grew without a configuration write");

  // A result reports size zero exactly when it reports an index error.
  a_err_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.index_error == (out_r.set_size == '0)))
    else $error("set size and index error disagree");

endmodule
`default_nettype wire
